>>> sv/occ_pkg.sv
// Shared types and constants for the ray-cast occupancy grid.
// No dependencies; imported by the top level and the testbench.
package occ_pkg;

  // Half width of the square freed round the sensor cell
  localparam int HALF_SPAN = 3;
  localparam int FREE_SPAN = 2 * HALF_SPAN + 1;

  // Operation codes of the input transaction
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_POINT = 2'd1,
    OP_FREE  = 2'd2,
    OP_READ  = 2'd3
  } opcode_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_HEIGHT = 2'd1,
    ST_RANGE  = 2'd2,
    ST_OUTSIDE = 2'd3
  } status_t;

  // Register indexes of the configuration port
  typedef enum logic [2:0] {
    REG_CELL_SIZE = 3'd0,
    REG_MIN_Z     = 3'd1,
    REG_MAX_Z     = 3'd2,
    REG_RANGE     = 3'd3,
    REG_FREE_THR  = 3'd4,
    REG_HIT_COST  = 3'd5,
    REG_FILL_COST = 3'd6
  } reg_idx_t;

  // Main sequencer states
  typedef enum logic [3:0] {
    S_SWEEP,
    S_IDLE,
    S_HEIGHT,
    S_RANGE_X,
    S_RANGE_Y,
    S_RANGE_R,
    S_QUANT_X,
    S_WAIT_X,
    S_QUANT_Y,
    S_WAIT_Y,
    S_SETUP,
    S_WALK,
    S_DRAIN,
    S_FREE,
    S_READ,
    S_DONE
  } state_t;

endpackage

>>> sv/lidar_raycast_occupancy_grid.sv
// Top level of the ray-cast occupancy grid: sequencer, registers, ray walker.
// Depends on occ_pkg, occ_grid_mem and occ_div.
//
//  channel | handshake         | payload
//  in      | in_valid/in_stall | in_opcode, in_point_x/y/z_mm, in_read_col/row
//  out     | out_valid/out_stall | out_status, out_cell_cost, out_ray_cells
//  cfg     | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// Clearing the grid writes one memory word per cycle. A point is rejected on
// height first, then on range; else it passes two serial quantizer divisions
// and a ray walk that reads its cells one at a time through the single read
// port of the grid memory.
// After reset a zeroing sweep of every grid word holds in_stall.
// The result register frees the sequencer: a new transaction is taken while
// a result still waits under out_stall.
module lidar_raycast_occupancy_grid
  import occ_pkg::*;
#(
  parameter int GRID_SIDE = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic signed [15:0] in_point_x_mm,
  input  logic signed [15:0] in_point_y_mm,
  input  logic signed [15:0] in_point_z_mm,
  input  logic [7:0]  in_read_col,
  input  logic [7:0]  in_read_row,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [6:0]  out_cell_cost,
  output logic [8:0]  out_ray_cells,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW   = $clog2(GRID_SIDE);
  localparam int AW   = 2 * CW;
  localparam int NW   = CW + 19;
  localparam int EW   = CW + 3;
  localparam logic [CW-1:0] C0 = CW'(GRID_SIDE / 2);
  localparam logic [CW-1:0] F0 = CW'(GRID_SIDE / 2 - HALF_SPAN);

  // configuration registers
  logic [9:0]  cell_size_r;
  logic [15:0] min_z_r, max_z_r;
  logic [14:0] range_r;
  logic [6:0]  free_thr_r, hit_cost_r, fill_cost_r;

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_size_r <= 10'd50;
      min_z_r     <= 16'hFE0C;
      max_z_r     <= 16'd500;
      range_r     <= 15'd25000;
      free_thr_r  <= 7'd10;
      hit_cost_r  <= 7'd100;
      fill_cost_r <= 7'd0;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_CELL_SIZE: cell_size_r <= pwdata[9:0];
        REG_MIN_Z:     min_z_r     <= pwdata[15:0];
        REG_MAX_Z:     max_z_r     <= pwdata[15:0];
        REG_RANGE:     range_r     <= pwdata[14:0];
        REG_FREE_THR:  free_thr_r  <= pwdata[6:0];
        REG_HIT_COST:  hit_cost_r  <= pwdata[6:0];
        REG_FILL_COST: fill_cost_r <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[4:2])
      REG_CELL_SIZE: prdata = {22'd0, cell_size_r};
      REG_MIN_Z:     prdata = {16'd0, min_z_r};
      REG_MAX_Z:     prdata = {16'd0, max_z_r};
      REG_RANGE:     prdata = {17'd0, range_r};
      REG_FREE_THR:  prdata = {25'd0, free_thr_r};
      REG_HIT_COST:  prdata = {25'd0, hit_cost_r};
      REG_FILL_COST: prdata = {25'd0, fill_cost_r};
      default:       prdata = '0;
    endcase
  end

  // sequencer and datapath registers
  state_t state_r, state_nxt;
  logic [1:0]  op_r, op_nxt;
  logic signed [15:0] x_r, y_r, z_r, x_nxt, y_nxt, z_nxt;
  logic [7:0]  rcol_r, rrow_r, rcol_nxt, rrow_nxt;
  logic [AW-1:0] sweep_r, sweep_nxt;
  logic [6:0]  sweep_val_r, sweep_val_nxt;
  logic [2:0]  fc_r, fr_r, fc_nxt, fr_nxt;
  logic [32:0] acc_r, acc_nxt;
  logic [NW-1:0] gx_r, gx_nxt;
  logic [CW-1:0] cx_r, cy_r, ex_r, ey_r, cx_nxt, cy_nxt, ex_nxt, ey_nxt;
  logic [CW:0]   dx_r, dy_r, dx_nxt, dy_nxt;
  logic          stx_r, sty_r, stx_nxt, sty_nxt;
  logic signed [EW-1:0] err_r, err_nxt;
  logic [8:0]  cnt_r, cnt_nxt;
  logic        p_valid_r, p_valid_nxt, p_last_r, p_last_nxt;
  logic [AW-1:0] p_addr_r, p_addr_nxt;
  logic [1:0]  res_status_r, res_status_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_status_r, out_status_nxt;
  logic [6:0]  out_cost_r, out_cost_nxt;
  logic [8:0]  out_cells_r, out_cells_nxt;

  // memory and divider hookups
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [6:0]    mem_wdata, mem_rdata;
  logic          div_start, div_done;
  logic [NW-1:0] div_num, div_quot;
  logic [10:0]   cell2;

  occ_grid_mem #(.AW(AW), .DW(7)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .re(mem_re), .raddr(mem_raddr), .rdata(mem_rdata)
  );

  occ_div #(.NW(NW), .DENW(11)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
    .den(cell2), .done(div_done), .quot(div_quot)
  );

  // quantizer numerator 2*v + GRID_SIDE*cell, signed
  logic [9:0]           cell_eff;
  logic [NW-1:0]        cell_off;
  logic signed [NW:0]   numq;
  logic signed [15:0]   qsrc;
  assign cell_eff = (cell_size_r == '0) ? 10'd1 : cell_size_r;
  assign cell2    = {cell_eff, 1'b0};
  assign cell_off = NW'(GRID_SIDE) * NW'(cell_eff);
  assign qsrc     = (state_r == S_QUANT_X) ? x_r : y_r;
  assign numq     = (NW+1)'($signed({qsrc, 1'b0})) + $signed({1'b0, cell_off});
  assign div_num  = numq[NW-1:0];

  // shared squarer for the range test
  logic [15:0] sq_a;
  logic [31:0] sq_p;
  always_comb begin
    case (state_r)
      S_RANGE_X: sq_a = x_r[15] ? 16'(-x_r) : 16'(x_r);
      S_RANGE_Y: sq_a = y_r[15] ? 16'(-y_r) : 16'(y_r);
      default:   sq_a = {1'b0, range_r};
    endcase
  end
  assign sq_p = sq_a * sq_a;

  // Bresenham step terms
  logic signed [EW-1:0] e2;
  logic step_x, step_y, at_end;
  assign e2     = err_r <<< 1;
  assign step_x = e2 > -$signed(EW'(dy_r));
  assign step_y = e2 < $signed(EW'(dx_r));
  assign at_end = (cx_r == ex_r) && (cy_r == ey_r);

  logic in_acc, out_acc;
  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid_r && !out_stall;
  assign in_stall = (state_r != S_IDLE);

  logic read_in_grid;
  assign read_in_grid = (13'(rcol_r) < 13'(GRID_SIDE)) && (13'(rrow_r) < 13'(GRID_SIDE));

  // next state and datapath
  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r; x_nxt = x_r; y_nxt = y_r; z_nxt = z_r;
    rcol_nxt = rcol_r; rrow_nxt = rrow_r;
    sweep_nxt = sweep_r; sweep_val_nxt = sweep_val_r;
    fc_nxt = fc_r; fr_nxt = fr_r;
    acc_nxt = acc_r; gx_nxt = gx_r;
    cx_nxt = cx_r; cy_nxt = cy_r; ex_nxt = ex_r; ey_nxt = ey_r;
    dx_nxt = dx_r; dy_nxt = dy_r; stx_nxt = stx_r; sty_nxt = sty_r;
    err_nxt = err_r; cnt_nxt = cnt_r;
    p_valid_nxt = 1'b0; p_last_nxt = 1'b0;
    p_addr_nxt = {cy_r, cx_r};
    res_status_nxt = res_status_r;
    out_valid_nxt = out_valid_r && !out_acc;
    out_status_nxt = out_status_r; out_cost_nxt = out_cost_r;
    out_cells_nxt = out_cells_r;
    mem_we = 1'b0; mem_waddr = sweep_r; mem_wdata = sweep_val_r;
    mem_re = 1'b0; mem_raddr = {cy_r, cx_r};
    div_start = 1'b0;

    // finish the read-modify-write of the previous ray cell
    if (p_valid_r) begin
      mem_waddr = p_addr_r;
      if (p_last_r) begin
        mem_we    = 1'b1;
        mem_wdata = hit_cost_r;
      end else if (mem_rdata < free_thr_r) begin
        mem_we    = 1'b1;
        mem_wdata = '0;
      end
    end

    unique case (state_r)
      S_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_r;
        mem_wdata = sweep_val_r;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == '1) begin
          state_nxt = (op_r == OP_CLEAR) ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          op_nxt = in_opcode; x_nxt = in_point_x_mm; y_nxt = in_point_y_mm;
          z_nxt = in_point_z_mm; rcol_nxt = in_read_col; rrow_nxt = in_read_row;
          res_status_nxt = ST_DONE; cnt_nxt = '0;
          unique case (in_opcode)
            OP_CLEAR: begin
              sweep_nxt = '0; sweep_val_nxt = fill_cost_r; state_nxt = S_SWEEP;
            end
            OP_POINT: state_nxt = S_HEIGHT;
            OP_FREE: begin
              fc_nxt = '0; fr_nxt = '0; state_nxt = S_FREE;
            end
            default: state_nxt = S_READ;
          endcase
        end
      end
      S_HEIGHT: begin
        if (z_r > $signed(max_z_r) || z_r < $signed(min_z_r)) begin
          res_status_nxt = ST_HEIGHT; state_nxt = S_DONE;
        end else begin
          state_nxt = S_RANGE_X;
        end
      end
      S_RANGE_X: begin
        acc_nxt = {1'b0, sq_p}; state_nxt = S_RANGE_Y;
      end
      S_RANGE_Y: begin
        acc_nxt = acc_r + {1'b0, sq_p}; state_nxt = S_RANGE_R;
      end
      S_RANGE_R: begin
        if (acc_r > {1'b0, sq_p}) begin
          res_status_nxt = ST_RANGE; state_nxt = S_DONE;
        end else begin
          state_nxt = S_QUANT_X;
        end
      end
      S_QUANT_X, S_QUANT_Y: begin
        if (numq < 0) begin
          res_status_nxt = ST_OUTSIDE; state_nxt = S_DONE;
        end else begin
          div_start = 1'b1;
          state_nxt = (state_r == S_QUANT_X) ? S_WAIT_X : S_WAIT_Y;
        end
      end
      S_WAIT_X: begin
        if (div_done) begin
          gx_nxt = div_quot; state_nxt = S_QUANT_Y;
        end
      end
      S_WAIT_Y: begin
        if (div_done) begin
          if (gx_r >= NW'(GRID_SIDE) || div_quot >= NW'(GRID_SIDE)) begin
            res_status_nxt = ST_OUTSIDE; state_nxt = S_DONE;
          end else begin
            ex_nxt = gx_r[CW-1:0]; ey_nxt = div_quot[CW-1:0];
            state_nxt = S_SETUP;
          end
        end
      end
      S_SETUP: begin
        cx_nxt = C0; cy_nxt = C0;
        stx_nxt = ex_r > C0; sty_nxt = ey_r > C0;
        dx_nxt = (ex_r > C0) ? {1'b0, ex_r - C0} : {1'b0, C0 - ex_r};
        dy_nxt = (ey_r > C0) ? {1'b0, ey_r - C0} : {1'b0, C0 - ey_r};
        err_nxt = $signed(EW'(dx_nxt)) - $signed(EW'(dy_nxt));
        state_nxt = S_WALK;
      end
      S_WALK: begin
        mem_re = 1'b1; mem_raddr = {cy_r, cx_r};
        p_valid_nxt = 1'b1; p_last_nxt = at_end; p_addr_nxt = {cy_r, cx_r};
        if (cnt_r != 9'd511) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        if (at_end) begin
          state_nxt = S_DRAIN;
        end else begin
          err_nxt = err_r - (step_x ? $signed(EW'(dy_r)) : '0)
                          + (step_y ? $signed(EW'(dx_r)) : '0);
          if (step_x) cx_nxt = stx_r ? cx_r + 1'b1 : cx_r - 1'b1;
          if (step_y) cy_nxt = sty_r ? cy_r + 1'b1 : cy_r - 1'b1;
        end
      end
      S_DRAIN: state_nxt = S_DONE;
      S_FREE: begin
        mem_we = 1'b1; mem_waddr = {F0 + CW'(fr_r), F0 + CW'(fc_r)}; mem_wdata = '0;
        if (fc_r == 3'(FREE_SPAN - 1)) begin
          fc_nxt = '0;
          fr_nxt = fr_r + 1'b1;
          if (fr_r == 3'(FREE_SPAN - 1)) state_nxt = S_DONE;
        end else begin
          fc_nxt = fc_r + 1'b1;
        end
      end
      S_READ: begin
        if (read_in_grid) begin
          mem_re = 1'b1; mem_raddr = {CW'(rrow_r), CW'(rcol_r)};
          state_nxt = S_DRAIN;
        end else begin
          res_status_nxt = ST_OUTSIDE; state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_status_nxt = res_status_r;
          out_cost_nxt = (op_r == OP_READ && res_status_r == ST_DONE) ? mem_rdata : '0;
          out_cells_nxt = cnt_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      sweep_r     <= '0;
      sweep_val_r <= '0;
      op_r        <= OP_FREE;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      sweep_val_r <= sweep_val_nxt;
      op_r        <= op_nxt;
      p_valid_r   <= p_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt;
    rcol_r <= rcol_nxt; rrow_r <= rrow_nxt;
    fc_r <= fc_nxt; fr_r <= fr_nxt;
    acc_r <= acc_nxt; gx_r <= gx_nxt;
    cx_r <= cx_nxt; cy_r <= cy_nxt; ex_r <= ex_nxt; ey_r <= ey_nxt;
    dx_r <= dx_nxt; dy_r <= dy_nxt; stx_r <= stx_nxt; sty_r <= sty_nxt;
    err_r <= err_nxt; cnt_r <= cnt_nxt;
    p_last_r <= p_last_nxt; p_addr_r <= p_addr_nxt;
    res_status_r <= res_status_nxt;
    out_status_r <= out_status_nxt; out_cost_r <= out_cost_nxt;
    out_cells_r <= out_cells_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_cell_cost = out_cost_r;
  assign out_ray_cells = out_cells_r;

endmodule

>>> sv/occ_grid_mem.sv
// Cost grid storage: one write port, one read port, registered read data.
// Depends on nothing; instantiated by the top level.
module occ_grid_mem #(
  parameter int AW = 16,
  parameter int DW = 7
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/occ_div.sv
// Restoring divider, one quotient bit per cycle, for cell quantization.
// Depends on nothing; instantiated by the top level.
module occ_div #(
  parameter int NW = 27,
  parameter int DENW = 11
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [NW-1:0]   num,
  input  logic [DENW-1:0] den,
  output logic            done,
  output logic [NW-1:0]   quot
);

  localparam int CNTW = $clog2(NW + 1);

  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [DENW-1:0] rem_r, rem_nxt;
  logic [NW-1:0]   q_r, q_nxt;
  logic [DENW-1:0] den_r, den_nxt;
  logic            done_r, done_nxt;
  logic [DENW:0]   trial;

  // load on start, else one shift and subtract step
  always_comb begin
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    den_nxt  = den_r;
    done_nxt = 1'b0;
    trial    = {rem_r, q_r[NW-1]};
    if (start) begin
      cnt_nxt = CNTW'(NW);
      rem_nxt = '0;
      q_nxt   = num;
      den_nxt = den;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = DENW'(trial - {1'b0, den_r});
        q_nxt   = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DENW-1:0];
        q_nxt   = {q_r[NW-2:0], 1'b0};
      end
      done_nxt = (cnt_r == CNTW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

>>> test/testbench.sv
// Self-checking testbench for lidar_raycast_occupancy_grid: drives opcodes and
// register writes, predicts each result with a local grid model and compares.
// Depends on occ_pkg and the RTL of the block.
module testbench
  import occ_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SIDE = 256;
  localparam int WATCH_LIMIT = 400000;

  typedef struct packed {
    logic [1:0] status;
    logic [6:0] cost;
    logic [8:0] cells;
  } occ_result_t;

  logic clk, rst_n;
  logic in_valid, in_stall;
  logic [1:0] in_opcode;
  logic signed [15:0] in_point_x_mm, in_point_y_mm, in_point_z_mm;
  logic [7:0] in_read_col, in_read_row;
  logic out_valid, out_stall;
  logic [1:0] out_status;
  logic [6:0] out_cell_cost;
  logic [8:0] out_ray_cells;
  logic psel, penable, pwrite, pready;
  logic [4:0] paddr;
  logic [31:0] pwdata, prdata;

  lidar_raycast_occupancy_grid #(.GRID_SIDE(SIDE)) i_dut (.*);

  // predictor state
  logic [6:0] grid_cost [SIDE*SIDE];
  logic [9:0] cell_size;
  logic signed [15:0] min_z, max_z;
  logic [14:0] range_lim;
  logic [6:0] free_thr, hit_cost, fill_cost;
  occ_result_t pending_results[$];

  int errors = 0;
  int n_sent = 0, n_checked = 0;
  int send_idle_pct = 0, recv_stall_pct = 0;
  int quiet_cycles = 0;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic longint quantize(longint v, longint cs);
    longint num;
    num = 2 * v + SIDE * cs;
    if (num < 0) return -1;
    return num / (2 * cs);
  endfunction

  function automatic bit on_map(longint c, longint r);
    return c >= 0 && c < SIDE && r >= 0 && r < SIDE;
  endfunction

  // Bresenham walk from the sensor cell; returns cells visited
  function automatic int walk_ray(longint ex, longint ey);
    longint cx, cy, dx, dy, sx, sy, err, e2;
    int cnt;
    cx = SIDE / 2; cy = SIDE / 2;
    dx = ex > cx ? ex - cx : cx - ex;
    dy = ey > cy ? ey - cy : cy - ey;
    sx = cx < ex ? 1 : -1;
    sy = cy < ey ? 1 : -1;
    err = dx - dy;
    cnt = 0;
    forever begin
      if (on_map(cx, cy) && grid_cost[cy*SIDE+cx] < free_thr) grid_cost[cy*SIDE+cx] = 0;
      if (cnt < 511) cnt++;
      if (cx == ex && cy == ey) break;
      e2 = 2 * err;
      if (e2 > -dy) begin err -= dy; cx += sx; end
      if (e2 < dx) begin err += dx; cy += sy; end
    end
    grid_cost[ey*SIDE+ex] = hit_cost;
    return cnt;
  endfunction

  function automatic occ_result_t predict_cell(opcode_t op, longint x, longint y, longint z,
                                               int col, int row);
    occ_result_t res;
    longint cs, gx, gy, r;
    res = '0;
    case (op)
      OP_CLEAR: begin
        foreach (grid_cost[i]) grid_cost[i] = fill_cost;
      end
      OP_POINT: begin
        cs = (cell_size == 0) ? 1 : cell_size;
        r = range_lim;
        if (z > max_z || z < min_z) res.status = ST_HEIGHT;
        else if (x*x + y*y > r*r) res.status = ST_RANGE;
        else begin
          gx = quantize(x, cs);
          gy = quantize(y, cs);
          if (!on_map(gx, gy)) res.status = ST_OUTSIDE;
          else res.cells = walk_ray(gx, gy);
        end
      end
      OP_FREE: begin
        for (int c = SIDE/2 - HALF_SPAN; c <= SIDE/2 + HALF_SPAN; c++)
          for (int rr = SIDE/2 - HALF_SPAN; rr <= SIDE/2 + HALF_SPAN; rr++)
            grid_cost[rr*SIDE+c] = 0;
      end
      default: begin
        if (on_map(col, row)) res.cost = grid_cost[row*SIDE+col];
        else res.status = ST_OUTSIDE;
      end
    endcase
    return res;
  endfunction

  // send one transaction and record its expected result
  task automatic send_item(opcode_t op, logic [15:0] x = 0, logic [15:0] y = 0,
                           logic [15:0] z = 0, logic [7:0] col = 0, logic [7:0] row = 0);
    @(posedge clk);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    in_valid <= 1;
    in_opcode <= op;
    in_point_x_mm <= x; in_point_y_mm <= y; in_point_z_mm <= z;
    in_read_col <= col; in_read_row <= row;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_cell(op, $signed(x), $signed(y), $signed(z), col, row));
    n_sent++;
    in_valid <= 0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // register write over the APB-style port, block idle
  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_CELL_SIZE: cell_size = val[9:0];
      REG_MIN_Z:     min_z = val[15:0];
      REG_MAX_Z:     max_z = val[15:0];
      REG_RANGE:     range_lim = val[14:0];
      REG_FREE_THR:  free_thr = val[6:0];
      REG_HIT_COST:  hit_cost = val[6:0];
      REG_FILL_COST: fill_cost = val[6:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(int cs, int mnz, int mxz, int rg, int thr, int hit, int fill);
    wait_drained();
    write_reg(REG_CELL_SIZE, cs);
    write_reg(REG_MIN_Z, mnz);
    write_reg(REG_MAX_Z, mxz);
    write_reg(REG_RANGE, rg);
    write_reg(REG_FREE_THR, thr);
    write_reg(REG_HIT_COST, hit);
    write_reg(REG_FILL_COST, fill);
  endtask

  // result checker
  always @(posedge clk) begin
    occ_result_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d cost=%0d cells=%0d",
                 $time, out_status, out_cell_cost, out_ray_cells);
        errors++;
      end else begin
        exp_res = pending_results.pop_front();
        n_checked++;
        if (out_status !== exp_res.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_res.status, out_status);
          errors++;
        end
        if (out_cell_cost !== exp_res.cost) begin
          $display("%0t: cell_cost expected %0d actual %0d", $time, exp_res.cost,
                   out_cell_cost);
          errors++;
        end
        if (out_ray_cells !== exp_res.cells) begin
          $display("%0t: ray_cells expected %0d actual %0d", $time, exp_res.cells,
                   out_ray_cells);
          errors++;
        end
      end
    end
  end

  // receiver stall and watchdog
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCH_LIMIT) begin
      $display("watchdog expired with %0d results pending", pending_results.size());
      $display("FAIL");
      $finish;
    end
  end

  task automatic test_directed();
    send_item(OP_READ, 0, 0, 0, 128, 128);
    send_item(OP_POINT, 16'sd500, 16'sd0, 16'sd0);
    send_item(OP_POINT, -16'sd500, -16'sd300, 16'sd500);
    send_item(OP_POINT, 0, 0, 0);
    send_item(OP_READ, 0, 0, 0, 138, 128);
    send_item(OP_POINT, 0, 0, 16'sd501);
    send_item(OP_POINT, 0, 0, -16'sd501);
    send_item(OP_POINT, 16'sd25000, 16'sd1, 0);
    send_item(OP_POINT, 16'h8000, 16'h8000, 16'h8000);
    send_item(OP_POINT, -16'sd6401, 0, 0);
    send_item(OP_POINT, 16'sd6399, 16'sd6399, 0);
    send_item(OP_POINT, 16'sd6400, 0, 0);
    send_item(OP_READ, 0, 0, 0, 255, 255);
    send_item(OP_READ, 0, 0, 0, 0, 0);
    send_item(OP_FREE);
    send_item(OP_READ, 0, 0, 0, 131, 125);
    // pause until everything has arrived
    while (pending_results.size() != 0) @(posedge clk);
    send_item(OP_CLEAR);
    send_item(OP_READ, 0, 0, 0, 7, 200);
  endtask

  task automatic test_extreme_config();
    set_config(0, 16'h7fff, 16'h8000, 32767, 127, 127, 127);
    send_item(OP_POINT, 16'sd10, 0, 0);
    send_item(OP_CLEAR);
    send_item(OP_READ, 0, 0, 0, 3, 4);
    set_config(1000, 16'h8000, 16'h7fff, 0, 0, 0, 127);
    send_item(OP_POINT, 0, 0, 16'h7fff);
    send_item(OP_POINT, 1, 0, 0);
    set_config(1, 16'h8000, 16'h7fff, 32767, 127, 55, 80);
    send_item(OP_POINT, -16'sd128, 16'sd127, 0);
    send_item(OP_POINT, -16'sd129, 0, 0);
    send_item(OP_READ, 0, 0, 0, 0, 255);
  endtask

  task automatic random_item();
    int k;
    k = $urandom_range(99);
    if (k < 3) send_item(OP_CLEAR);
    else if (k < 6) send_item(OP_FREE);
    else if (k < 30) send_item(OP_READ, 0, 0, 0, 8'($urandom_range(255)),
                               8'($urandom_range(255)));
    else if (k < 40) send_item(OP_READ, 0, 0, 0, 8'(128 + $urandom_range(20) - 10),
                               8'(128 + $urandom_range(20) - 10));
    else if (k < 50) send_item(OP_POINT, 16'($urandom), 16'($urandom), 16'($urandom));
    else send_item(OP_POINT, 16'($urandom_range(12000) - 6000),
                   16'($urandom_range(12000) - 6000), 16'($urandom_range(1200) - 600));
  endtask

  task automatic test_random(int count, int cs, int thr, int hit, int fill);
    set_config(cs, -500, 500, 25000, thr, hit, fill);
    repeat (count) random_item();
  endtask

  initial begin
    rst_n = 0; in_valid = 0; in_opcode = OP_CLEAR;
    in_point_x_mm = 0; in_point_y_mm = 0; in_point_z_mm = 0;
    in_read_col = 0; in_read_row = 0; out_stall = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    foreach (grid_cost[i]) grid_cost[i] = 0;
    cell_size = 50; min_z = -500; max_z = 500; range_lim = 25000;
    free_thr = 10; hit_cost = 100; fill_cost = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_extreme_config();
    send_idle_pct = 27; recv_stall_pct = 51;
    test_random(370, 50, 60, 100, 30);
    send_idle_pct = 51; recv_stall_pct = 27;
    test_random(370, 37, 127, 5, 127);
    send_idle_pct = 0; recv_stall_pct = 0;
    test_random(370, 80, 10, 127, 0);
    wait_drained();
    $display("Covered %0d transactions (%0d results checked): clears, points, frees, reads",
             n_sent, n_checked);
    $display("under several register settings and three idle patterns.");
    if (errors == 0 && pending_results.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
